// File: rtl/tkst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkst_pkg
// Field widths, action codes, the table entry type and the sequencer states
// shared by the top-k score table.
// ----------------------------------------------------------------------------
package tkst_pkg;

  // field widths of the item and result transfers
  localparam int ID_W    = 32;
  localparam int LEVEL_W = 16;
  localparam int SCORE_W = 31;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 4;

  // action codes
  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/top_k_score_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_score_table
// Descending top-k table of (id, level, score) entries held in one memory.
//
// Input channel (in_valid / in_stall): action 0 submits an entry, action 1
// reads one slot. Output channel (out_valid / out_stall): one result per item.
// The block takes one item at a time; in_stall is high from acceptance until
// the result has been moved into the output register.
// A read fetches the requested slot; a submit whose score does not beat the
// last slot goes straight to its result; one that enters the table walks the
// memory, dropping the first entry with the same id that it meets.
// A submit is one walk over the memory, one entry per cycle: the read port
// streams the old table while the write port stores the new one behind it.
// The next item is taken in the cycle after the result is registered, even
// while that result is still stalled by the receiver; the block then waits
// at the end of its next item until the output register is free.
// Reset (rst, synchronous) clears per-entry valid bits, so the whole table
// reads as zero at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module top_k_score_table #(
  parameter int TABLE_DEPTH = 10
) (
  input  wire                            clk,
  input  wire                            rst,
  // item transfer
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            action,
  input  wire  [tkst_pkg::ID_W-1:0]      user_id,
  input  wire  [tkst_pkg::LEVEL_W-1:0]   user_level,
  input  wire  [tkst_pkg::SCORE_W-1:0]   user_score,
  input  wire  [tkst_pkg::SLOT_W-1:0]    slot,
  // result transfer
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           accepted,
  output logic [tkst_pkg::POS_W-1:0]     position,
  output logic [tkst_pkg::ID_W-1:0]      entry_id,
  output logic [tkst_pkg::LEVEL_W-1:0]   entry_level,
  output logic [tkst_pkg::SCORE_W-1:0]   entry_score,
  output logic [tkst_pkg::SCORE_W-1:0]   lowest_score
);
  import tkst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = $clog2(TABLE_DEPTH + 1);
  localparam logic [RW-1:0]    DEPTH_R   = RW'(TABLE_DEPTH);
  localparam logic [RW-1:0]    LAST_R    = RW'(TABLE_DEPTH - 1);
  localparam logic [POS_W-1:0] NO_PLACE  = POS_W'(TABLE_DEPTH);
  localparam logic [31:0]      DEPTH_32  = 32'(TABLE_DEPTH);

  // table memory and per-entry valid bits
  entry_t                 mem [TABLE_DEPTH];
  entry_t                 mem_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  entry_t                 mem_wd;
  logic [AW-1:0]          mem_ra;
  logic [TABLE_DEPTH-1:0] vld;

  // sequencer and walk registers
  state_t             state, state_next;
  logic [RW-1:0]      rd_idx, rd_idx_next;
  logic [RW-1:0]      wr_idx, wr_idx_next;
  logic               rd_vld, rd_vld_next;
  logic               removed, removed_next;
  logic               ins, ins_next;
  entry_t             hold, hold_next;
  logic [SCORE_W-1:0] lowest, lowest_next;

  // captured item
  logic               it_action, it_action_next;
  entry_t             it_entry, it_entry_next;

  // pending result
  logic               res_accepted, res_accepted_next;
  logic [POS_W-1:0]   res_position, res_position_next;
  entry_t             res_entry, res_entry_next;

  // output register next values
  logic               out_valid_next;
  logic               accepted_next;
  logic [POS_W-1:0]   position_next;
  entry_t             out_entry_next;
  logic [SCORE_W-1:0] lowest_score_next;

  assign in_stall = (state != ST_IDLE);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // valid bits: an entry reads as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_wa] <= 1'b1;
    end
  end

  // next state, walk datapath and result
  always_comb begin
    entry_t e_cur;
    logic   in_range;
    logic   slot_vld;

    e_cur    = rd_vld ? mem_q : '0;
    in_range = ({28'd0, slot} < DEPTH_32);
    slot_vld = in_range & vld[AW'(slot)];

    state_next        = state;
    rd_idx_next       = rd_idx;
    wr_idx_next       = wr_idx;
    rd_vld_next       = rd_vld;
    removed_next      = removed;
    ins_next          = ins;
    hold_next         = hold;
    lowest_next       = lowest;
    it_action_next    = it_action;
    it_entry_next     = it_entry;
    res_accepted_next = res_accepted;
    res_position_next = res_position;
    res_entry_next    = res_entry;

    out_valid_next    = out_valid & out_stall;
    accepted_next     = accepted;
    position_next     = position;
    out_entry_next    = '{id: entry_id, level: entry_level, score: entry_score};
    lowest_score_next = lowest_score;

    mem_we = 1'b0;
    mem_wa = wr_idx[AW-1:0];
    mem_wd = e_cur;
    mem_ra = rd_idx[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          it_action_next    = action;
          it_entry_next     = '{id: user_id, level: user_level, score: user_score};
          res_accepted_next = 1'b0;
          res_position_next = NO_PLACE;
          res_entry_next    = '0;
          if (action == ACT_READ) begin
            // fetch the requested slot
            mem_ra      = AW'(slot);
            rd_vld_next = slot_vld;
            state_next  = ST_READ;
          end else if (user_score > lowest) begin
            // start the walk at slot 0
            mem_ra            = '0;
            rd_vld_next       = vld[0];
            rd_idx_next       = RW'(1);
            wr_idx_next       = '0;
            removed_next      = 1'b0;
            ins_next          = 1'b0;
            res_accepted_next = 1'b1;
            state_next        = ST_WALK;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_WALK: begin
        // stream element: old entry, the first id match skipped
        if (!removed && (e_cur.id == it_entry.id)) begin
          removed_next = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (!ins && (it_entry.score > e_cur.score)) begin
            mem_wd            = it_entry;
            hold_next         = e_cur;
            ins_next          = 1'b1;
            res_position_next = POS_W'(wr_idx);
          end else if (ins) begin
            mem_wd    = hold;
            hold_next = e_cur;
          end else begin
            mem_wd = e_cur;
          end
          wr_idx_next = wr_idx + RW'(1);
          if (wr_idx == LAST_R) begin
            lowest_next = mem_wd.score;
            state_next  = ST_DONE;
          end
        end
        // issue the next read ahead of the write pointer
        rd_vld_next = (rd_idx < DEPTH_R) & vld[rd_idx[AW-1:0]];
        if (rd_idx < DEPTH_R) begin
          rd_idx_next = rd_idx + RW'(1);
        end
      end

      ST_READ: begin
        res_entry_next = e_cur;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        // load the output register once it is free
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          accepted_next     = res_accepted;
          position_next     = res_position;
          out_entry_next    = res_entry;
          lowest_score_next = lowest;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      lowest    <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      lowest    <= lowest_next;
    end
  end

  // walk, item and result registers
  always_ff @(posedge clk) begin
    rd_idx       <= rd_idx_next;
    wr_idx       <= wr_idx_next;
    rd_vld       <= rd_vld_next;
    removed      <= removed_next;
    ins          <= ins_next;
    hold         <= hold_next;
    it_action    <= it_action_next;
    it_entry     <= it_entry_next;
    res_accepted <= res_accepted_next;
    res_position <= res_position_next;
    res_entry    <= res_entry_next;
    accepted     <= accepted_next;
    position     <= position_next;
    entry_id     <= out_entry_next.id;
    entry_level  <= out_entry_next.level;
    entry_score  <= out_entry_next.score;
    lowest_score <= lowest_score_next;
  end

`ifndef NO_ASSERTIONS
  // the write pointer never runs past the table during a walk
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (wr_idx < DEPTH_R))
    else $error("walk write pointer beyond table");

  // reads stay strictly ahead of writes, so no entry is overwritten unread
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (rd_idx > wr_idx))
    else $error("walk read pointer not ahead of write pointer");

  // a walk always places the new entry before it ends
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && $past(state) == ST_WALK) |-> ins)
    else $error("walk ended without placing the entry");

  // only a submit walk is reported as accepted
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_accepted) |-> (it_action == ACT_SUBMIT))
    else $error("accepted result for a read item");

  // a result that did not place an entry carries the not-placed position
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (position == NO_PLACE))
    else $error("unplaced result with a real position");
`endif

endmodule

`default_nettype wire
